FILE: rtl/bb3_pkg.sv
// shared types and constants of the 3x3 box blur with replicated borders
// no dependencies; every other file imports this package
`default_nettype none

package bb3_pkg;

   // line store geometry
   localparam int unsigned MAX_WIDTH = 1024;
   localparam int unsigned ADDR_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   // field and register widths
   localparam int unsigned FW_W  = 11;
   localparam int unsigned FH_W  = 16;
   localparam int unsigned PIX_W = 8;
   localparam int unsigned COL_W = 10;   // sum of three pixels
   localparam int unsigned SUM_W = 12;   // sum of nine pixels

   // divide by nine: multiply by 2^16/9 rounded up, keep bits from 16 up
   localparam int unsigned RECIP       = 7282;
   localparam int unsigned RECIP_W     = 13;
   localparam int unsigned RECIP_SHIFT = 16;
   localparam int unsigned PROD_W      = SUM_W + RECIP_W;

   // register file
   localparam int unsigned CSR_AW = 3;
   localparam int unsigned CSR_DW = 32;
   localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
   localparam logic [FH_W-1:0] FH_RESET = 16'd1024;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_idx_type;

   // kind of input transaction
   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } op_kind_type;

   // classified operation handed from the front end to the filter
   typedef struct packed {
      op_kind_type       kind;
      logic [PIX_W-1:0]  pixel;
      logic [ADDR_W-1:0] addr;       // column, or flush look-ahead column
      logic              first_row;
      logic              second_row;
      logic              last_row;
      logic              col_first;
      logic              col_last;
      logic              eof;        // flush of the bottom-right pixel
      logic              top_upper;  // frame has two or more rows
   } op_type;

   // nine-pixel sum waiting for the divider
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             eor;
      logic             eof;
   } res_type;

   // queue geometry
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = 2;

endpackage

`default_nettype wire

FILE: rtl/bb3_front.sv
// front end: register file, frame position counters, classification of input
// transactions into filter operations; uses bb3_pkg
`default_nettype none

module bb3_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [bb3_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [bb3_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic      [bb3_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                             csr_pready,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [bb3_pkg::PIX_W-1:0]   req_tdata,   // [7:0] pixel_in
   input  wire logic [0:0]                  req_tuser,   // [0] mode
   output logic                             op_push,
   output bb3_pkg::op_type                  op_data,
   input  wire logic                        op_full
);
   import bb3_pkg::*;

   logic [FW_W-1:0]   fw_ff, fw_in;
   logic [FH_W-1:0]   fh_ff, fh_in;
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [FH_W-1:0]   row_ff, row_in;
   logic [ADDR_W-1:0] flush_ff, flush_in;
   logic              flushing_ff, flushing_in;

   logic              csr_wr;
   reg_idx_type       reg_sel;
   logic [ADDR_W-1:0] wlast;
   logic [FH_W-1:0]   hlast;
   logic [ADDR_W-1:0] flush_addr;
   op_kind_type       in_kind;
   logic              accept;
   logic              pix_go;
   logic              flu_go;
   logic              col_last;
   logic              last_row;
   logic              flush_eof;

   // register access
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = reg_idx_type'(csr_paddr[CSR_AW-1]);

   always_comb begin
      unique case (reg_sel)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DW'(fw_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DW'(fh_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // effective last column and last row
   always_comb begin
      if (fw_ff == '0) begin
         wlast = '0;
      end else if (32'(fw_ff) >= MAX_WIDTH) begin
         wlast = ADDR_W'(MAX_WIDTH - 1);
      end else begin
         wlast = ADDR_W'(fw_ff - 1'b1);
      end
   end

   assign hlast = (fh_ff == '0) ? '0 : fh_ff - 1'b1;

   // classification
   assign in_kind    = op_kind_type'(req_tuser[0]);
   assign req_tready = !op_full;
   assign accept     = req_tvalid && !op_full;
   assign pix_go     = accept && (in_kind == OP_PIXEL) && !flushing_ff;
   assign flu_go     = accept && (in_kind == OP_FLUSH) && flushing_ff;
   assign col_last   = (col_ff == wlast);
   assign last_row   = (row_ff == hlast);
   assign flush_eof  = (flush_ff == wlast);
   assign flush_addr = flush_eof ? flush_ff : flush_ff + 1'b1;

   assign op_push = pix_go || flu_go;

   always_comb begin
      op_data            = '0;
      op_data.kind       = in_kind;
      op_data.pixel      = req_tdata;
      op_data.addr       = flushing_ff ? flush_addr : col_ff;
      op_data.first_row  = (row_ff == '0);
      op_data.second_row = (row_ff == FH_W'(1));
      op_data.last_row   = last_row;
      op_data.col_first  = (col_ff == '0);
      op_data.col_last   = col_last;
      op_data.eof        = flush_eof;
      op_data.top_upper  = (hlast != '0);
   end

   // position counters, restarted by any register write
   always_comb begin
      fw_in       = fw_ff;
      fh_in       = fh_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      flush_in    = flush_ff;
      flushing_in = flushing_ff;
      if (csr_wr) begin
         unique case (reg_sel)
            REG_FRAME_WIDTH:  fw_in = csr_pwdata[FW_W-1:0];
            REG_FRAME_HEIGHT: fh_in = csr_pwdata[FH_W-1:0];
            default:          fw_in = fw_ff;
         endcase
         col_in      = '0;
         row_in      = '0;
         flush_in    = '0;
         flushing_in = 1'b0;
      end else if (pix_go) begin
         if (col_last) begin
            col_in = '0;
            if (last_row) begin
               row_in      = '0;
               flushing_in = 1'b1;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end else if (flu_go) begin
         if (flush_eof) begin
            flush_in    = '0;
            flushing_in = 1'b0;
         end else begin
            flush_in = flush_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff       <= FW_RESET;
         fh_ff       <= FH_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         flush_ff    <= '0;
         flushing_ff <= 1'b0;
      end else begin
         fw_ff       <= fw_in;
         fh_ff       <= fh_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         flush_ff    <= flush_in;
         flushing_ff <= flushing_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/bb3_queue.sv
// short operation queue between the front end and the filter
// uses bb3_pkg
`default_nettype none

module bb3_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire bb3_pkg::op_type push_data,
   input  wire logic            pop,
   output bb3_pkg::op_type      head,
   output logic                 empty,
   output logic                 full
);
   import bb3_pkg::*;

   op_type            entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   // pointers and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/bb3_back.sv
// filter back end: two line stores, the 3x3 window kept as column sums and the
// bottom-row flush window; produces nine-pixel sums; uses bb3_pkg
`default_nettype none

module bb3_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire bb3_pkg::op_type q_head,
   input  wire logic            q_empty,
   output logic                 q_pop,
   output logic                 res_push,
   output bb3_pkg::res_type     res_data,
   input  wire logic            res_full
);
   import bb3_pkg::*;

   // line stores: previous row and the row before it
   logic [PIX_W-1:0] line_lower_ff [MAX_WIDTH];
   logic [PIX_W-1:0] line_upper_ff [MAX_WIDTH];
   logic [PIX_W-1:0] lower_rd_ff;
   logic [PIX_W-1:0] upper_rd_ff;

   // same-cycle write forwarding
   logic             byp_lo_hit_ff, byp_lo_hit_in;
   logic             byp_up_hit_ff, byp_up_hit_in;
   logic [PIX_W-1:0] byp_lo_ff;
   logic [PIX_W-1:0] byp_up_ff;

   // operation in the filter stage
   logic   b_vld_ff, b_vld_in;
   op_type b_op_ff;
   logic   phase_ff, phase_in;

   // window column sums, flush column values
   logic [COL_W-1:0] win_ff [3];
   logic [COL_W-1:0] fa_ff;
   logic [COL_W-1:0] fb_ff;

   logic [PIX_W-1:0] lower_v;
   logic [PIX_W-1:0] upper_v;
   logic [PIX_W-1:0] col0;
   logic [PIX_W-1:0] col1;
   logic [PIX_W-1:0] flush_top;
   logic [COL_W-1:0] cs;
   logic [COL_W-1:0] fcol;
   logic [COL_W-1:0] flush_c;
   logic             is_pixel;
   logic             b_step;
   logic             b_done;
   logic             need_ph1;
   logic             wr_en;
   logic             wr_up_en;

   // read data with forwarding
   assign lower_v = byp_lo_hit_ff ? byp_lo_ff : lower_rd_ff;
   assign upper_v = byp_up_hit_ff ? byp_up_ff : upper_rd_ff;

   // column of the neighborhood, with the top border replicated
   assign col0 = b_op_ff.first_row  ? b_op_ff.pixel :
                 b_op_ff.second_row ? lower_v : upper_v;
   assign col1 = b_op_ff.first_row ? b_op_ff.pixel : lower_v;
   assign cs   = COL_W'(col0) + COL_W'(col1) + COL_W'(b_op_ff.pixel);

   // bottom-row column weights: row above once, bottom row twice
   assign fcol      = COL_W'(col1) + (COL_W'(b_op_ff.pixel) << 1);
   assign flush_top = b_op_ff.top_upper ? upper_v : lower_v;
   assign flush_c   = COL_W'(flush_top) + (COL_W'(lower_v) << 1);

   // stage control
   assign is_pixel = (b_op_ff.kind == OP_PIXEL);
   assign b_step   = b_vld_ff && !res_full;
   assign need_ph1 = is_pixel && b_op_ff.col_last && !b_op_ff.first_row;
   assign b_done   = b_step && (phase_ff || !need_ph1);
   assign q_pop    = !q_empty && (!b_vld_ff || b_done);
   assign wr_en    = b_step && !phase_ff && is_pixel;
   assign wr_up_en = wr_en && !b_op_ff.first_row;

   assign byp_lo_hit_in = wr_en && (b_op_ff.addr == q_head.addr);
   assign byp_up_hit_in = wr_up_en && (b_op_ff.addr == q_head.addr);

   // result sums
   always_comb begin
      res_push     = 1'b0;
      res_data     = '0;
      if (!is_pixel) begin
         res_push     = b_step;
         res_data.sum = SUM_W'(fa_ff) + SUM_W'(fb_ff) + SUM_W'(flush_c);
         res_data.eor = 1'b1;
         res_data.eof = b_op_ff.eof;
      end else if (phase_ff) begin
         // right border: last column counted twice
         res_push     = b_step;
         res_data.sum = SUM_W'(win_ff[1]) + (SUM_W'(win_ff[2]) << 1);
         res_data.eor = 1'b1;
      end else begin
         res_push     = b_step && !b_op_ff.first_row && !b_op_ff.col_first;
         res_data.sum = SUM_W'(win_ff[1]) + SUM_W'(win_ff[2]) + SUM_W'(cs);
         res_data.eor = !b_op_ff.col_last;
      end
   end

   // stage valid and row-end phase
   always_comb begin
      b_vld_in = b_vld_ff;
      phase_in = phase_ff;
      if (q_pop) begin
         b_vld_in = 1'b1;
      end else if (b_done) begin
         b_vld_in = 1'b0;
      end
      if (b_done) begin
         phase_in = 1'b0;
      end else if (b_step && need_ph1) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         b_vld_ff <= b_vld_in;
         phase_ff <= phase_in;
      end
   end

   // operation register and forwarding capture
   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_op_ff       <= q_head;
         byp_lo_hit_ff <= byp_lo_hit_in;
         byp_up_hit_ff <= byp_up_hit_in;
         byp_lo_ff     <= b_op_ff.pixel;
         byp_up_ff     <= lower_v;
      end
   end

   // line store read and write
   always_ff @(posedge clock) begin
      if (q_pop) begin
         lower_rd_ff <= line_lower_ff[q_head.addr];
         upper_rd_ff <= line_upper_ff[q_head.addr];
      end
      if (wr_en) begin
         line_lower_ff[b_op_ff.addr] <= b_op_ff.pixel;
      end
      if (wr_up_en) begin
         line_upper_ff[b_op_ff.addr] <= lower_v;
      end
   end

   // window shift, left border replicated
   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (b_op_ff.col_first) begin
            win_ff[0] <= cs;
            win_ff[1] <= cs;
         end else begin
            win_ff[0] <= win_ff[1];
            win_ff[1] <= win_ff[2];
         end
         win_ff[2] <= cs;
      end
   end

   // flush window: seeded at the start of the last row, slides per flush
   always_ff @(posedge clock) begin
      if (wr_en && b_op_ff.last_row && b_op_ff.col_first) begin
         fa_ff <= fcol;
         fb_ff <= fcol;
      end else if (b_step && !is_pixel) begin
         fa_ff <= fb_ff;
         fb_ff <= flush_c;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/bb3_out.sv
// result queue, divide by nine and output register
// uses bb3_pkg
`default_nettype none

module bb3_out (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      res_push,
   input  wire bb3_pkg::res_type          res_data,
   output logic                           res_full,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [bb3_pkg::PIX_W-1:0]      rsp_tdata,   // [7:0] pixel_out
   output logic                           rsp_tlast,   // end_of_run
   output logic [0:0]                     rsp_tuser    // [0] end_of_frame
);
   import bb3_pkg::*;

   res_type           rq_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;

   logic              rsp_vld_ff, rsp_vld_in;
   logic [PIX_W-1:0]  pix_ff, pix_in;
   logic              last_ff;
   logic              eof_ff;

   res_type           head;
   logic              empty;
   logic              pop;
   logic [PROD_W-1:0] prod;

   assign empty    = (cnt_ff == '0);
   assign res_full = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign head     = rq_ff[rd_ptr_ff];
   assign pop      = !empty && (!rsp_vld_ff || rsp_tready);

   // floor of sum / 9 by reciprocal multiply
   assign prod   = PROD_W'(head.sum) * PROD_W'(RECIP);
   assign pix_in = prod[RECIP_SHIFT +: PIX_W];

   // queue pointers and fill level
   always_comb begin
      wr_ptr_in = res_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (res_push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !res_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // output valid
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (pop) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         cnt_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         cnt_ff     <= cnt_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // storage and output payload
   always_ff @(posedge clock) begin
      if (res_push) begin
         rq_ff[wr_ptr_ff] <= res_data;
      end
      if (pop) begin
         pix_ff  <= pix_in;
         last_ff <= head.eor;
         eof_ff  <= head.eof;
      end
   end

   assign rsp_tvalid   = rsp_vld_ff;
   assign rsp_tdata    = pix_ff;
   assign rsp_tlast    = last_ff;
   assign rsp_tuser[0] = eof_ff;

endmodule

`default_nettype wire

FILE: rtl/box_blur_3x3_clamped_top.sv
// top level of the streaming 3x3 box blur with replicated borders
// instantiates bb3_front, bb3_queue, bb3_back and bb3_out; uses bb3_pkg
`default_nettype none

// Pixels enter in raster order, one transaction per clock at full rate unless
// the operation queue is full (req_tready low); each output is floor(sum of
// the 3x3 neighborhood / 9) with edge pixels repeated past the border.
// Outputs trail the input by one row and one column: the pixel that closes a
// row yields that row's last two outputs (it holds the filter stage for an
// extra row-end phase), and after the frame's last pixel one flush transaction
// (tuser = 1) per bottom-row output drains the frame; the bottom-right output
// carries tuser = 1 on the result side. tlast marks the last result of each
// input transaction. Pixels sent while the bottom row awaits flushing, and
// flushes sent before it, are taken and dropped. The line stores come up
// uninitialized and need no clearing; a register write restarts the frame and
// is allowed only while the block is idle.
module box_blur_3x3_clamped_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [bb3_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [bb3_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic      [bb3_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                             csr_pready,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [bb3_pkg::PIX_W-1:0]   req_tdata,   // [7:0] pixel_in
   input  wire logic [0:0]                  req_tuser,   // [0] mode
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic      [bb3_pkg::PIX_W-1:0]   rsp_tdata,   // [7:0] pixel_out
   output logic                             rsp_tlast,   // end_of_run
   output logic      [0:0]                  rsp_tuser    // [0] end_of_frame
);
   import bb3_pkg::*;

   logic    op_push;
   op_type  op_data;
   logic    op_full;
   op_type  q_head;
   logic    q_empty;
   logic    q_pop;
   logic    res_push;
   res_type res_data;
   logic    res_full;

   // classification and frame position
   bb3_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .op_push     (op_push),
      .op_data     (op_data),
      .op_full     (op_full)
   );

   // decoupling queue
   bb3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_data),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (op_full)
   );

   // line stores and window
   bb3_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .res_push (res_push),
      .res_data (res_data),
      .res_full (res_full)
   );

   // divide and output register
   bb3_out u_out (
      .clock      (clock),
      .reset      (reset),
      .res_push   (res_push),
      .res_data   (res_data),
      .res_full   (res_full),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

FILE: tb/tb_box_blur_3x3_clamped_top.sv
`timescale 1ns / 100ps
// self-checking bench for the 3x3 box blur with replicated borders
// drives box_blur_3x3_clamped_top through its stream and register ports; uses bb3_pkg

module tb_box_blur_3x3_clamped_top;
   import bb3_pkg::*;

   localparam int unsigned SETTLE_CYCLES  = 10;
   localparam int unsigned HOLDOFF_CYCLES = 200;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned RANDOM_ITEMS   = 80;
   localparam int unsigned WIDE_FLUSHES   = 16;

   // one stream transaction in each direction
   typedef struct packed {
      op_kind_type      kind;
      logic [PIX_W-1:0] pixel;
   } blur_req_t;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             eor;
      logic             eof;
   } blur_rsp_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [PIX_W-1:0]    req_tdata = '0;   // [7:0] pixel_in
   logic [0:0]          req_tuser = '0;   // [0] mode
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [PIX_W-1:0]    rsp_tdata;        // [7:0] pixel_out
   logic                rsp_tlast;
   logic [0:0]          rsp_tuser;        // [0] end_of_frame

   box_blur_3x3_clamped_top dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // pending input, expected output, bookkeeping
   blur_req_t   pixel_stream [$];
   blur_rsp_t   expected_blur [$];
   blur_req_t   next_req;
   blur_rsp_t   want;
   int unsigned items_queued = 0;
   int unsigned items_taken  = 0;
   int unsigned fail_count   = 0;
   int unsigned quiet_cycles = 0;
   int unsigned send_idle_pct = 34;
   int unsigned recv_idle_pct = 34;
   int unsigned holdoff_asked  = 0;
   int unsigned holdoff_served = 0;
   int unsigned stall_left     = 0;

   // blur predictor state
   logic [PIX_W-1:0] upper_line [MAX_WIDTH];
   logic [PIX_W-1:0] lower_line [MAX_WIDTH];
   logic [PIX_W-1:0] win [9];
   logic [FW_W-1:0]  width_reg  = FW_RESET;
   logic [FH_W-1:0]  height_reg = FH_RESET;
   int unsigned      col_pos = 0;
   int unsigned      row_pos = 0;
   int unsigned      flush_pos = 0;

   initial begin
      for (int i = 0; i < 9; i++) win[i] = '0;
   end

   function automatic int unsigned eff_cols();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
   endfunction

   function automatic int unsigned eff_rows();
      return (height_reg == 0) ? 1 : height_reg;
   endfunction

   function automatic int unsigned window_total();
      int unsigned s;
      s = 0;
      for (int i = 0; i < 9; i++) s += win[i];
      return s;
   endfunction

   function automatic void push_blur(int unsigned sum, bit eor, bit eof);
      blur_rsp_t r;
      r.pixel = PIX_W'(sum / 9);
      r.eor   = eor;
      r.eof   = eof;
      expected_blur.push_back(r);
   endfunction

   // expected results of one accepted transaction
   function automatic void blur_predict(op_kind_type kind, logic [PIX_W-1:0] pix);
      int unsigned      w, h, x, y, k, lo, hi, sum;
      logic [PIX_W-1:0] column [3];
      bit               row_end;
      bit               two_rows;
      w = eff_cols();
      h = eff_rows();
      if (kind == OP_PIXEL) begin
         // pixel after the last row waits for flushing and is dropped
         if (row_pos >= h) return;
         x = (col_pos >= w) ? w - 1 : col_pos;
         y = row_pos;
         if (y == 0) begin
            column[0] = pix;
            column[1] = pix;
         end else if (y == 1) begin
            column[0] = lower_line[x];
            column[1] = lower_line[x];
         end else begin
            column[0] = upper_line[x];
            column[1] = lower_line[x];
         end
         column[2] = pix;
         // shift the window, or fill it with the left edge at column zero
         for (int r = 0; r < 3; r++) begin
            if (x == 0) begin
               win[r*3]   = column[r];
               win[r*3+1] = column[r];
            end else begin
               win[r*3]   = win[r*3+1];
               win[r*3+1] = win[r*3+2];
            end
            win[r*3+2] = column[r];
         end
         if (y >= 1) upper_line[x] = lower_line[x];
         lower_line[x] = pix;
         row_end = (x == w - 1);
         if (y >= 1 && x >= 1) push_blur(window_total(), !row_end, 1'b0);
         if (row_end) begin
            // right edge output repeats the last column
            if (y >= 1) begin
               for (int r = 0; r < 3; r++) begin
                  win[r*3]   = win[r*3+1];
                  win[r*3+1] = win[r*3+2];
               end
               push_blur(window_total(), 1'b1, 1'b0);
            end
            col_pos = 0;
            row_pos = y + 1;
         end else begin
            col_pos = x + 1;
         end
      end else begin
         // flush before the frame is complete is dropped
         if (row_pos < h) return;
         k  = (flush_pos >= w) ? w - 1 : flush_pos;
         lo = (k == 0) ? 0 : k - 1;
         hi = (k + 1 >= w) ? w - 1 : k + 1;
         two_rows = (h >= 2);
         sum = (two_rows ? upper_line[lo] : lower_line[lo]) + 2 * lower_line[lo]
             + (two_rows ? upper_line[k]  : lower_line[k])  + 2 * lower_line[k]
             + (two_rows ? upper_line[hi] : lower_line[hi]) + 2 * lower_line[hi];
         push_blur(sum, 1'b1, k == w - 1);
         if (k == w - 1) begin
            col_pos   = 0;
            row_pos   = 0;
            flush_pos = 0;
         end else begin
            flush_pos = k + 1;
         end
      end
   endfunction

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            blur_predict(op_kind_type'(req_tuser[0]), req_tdata);
            items_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (pixel_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_req = pixel_stream.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= next_req.kind;
               req_tdata  <= next_req.pixel;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blur.size() == 0) begin
               $error("unexpected result: pixel_out %0d", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_blur.pop_front();
               if (rsp_tdata !== want.pixel) begin
                  $error("pixel_out: expected %0d, actual %0d", want.pixel, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== want.eor) begin
                  $error("end_of_run: expected %0d, actual %0d", want.eor, rsp_tlast);
                  fail_count++;
               end
               if (rsp_tuser[0] !== want.eof) begin
                  $error("end_of_frame: expected %0d, actual %0d", want.eof, rsp_tuser[0]);
                  fail_count++;
               end
            end
         end
         if (holdoff_served != holdoff_asked) begin
            holdoff_served <= holdoff_asked;
            stall_left     <= HOLDOFF_CYCLES;
            rsp_tready     <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [PIX_W-1:0] rand_pixel();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return PIX_W'($urandom_range(255));
      endcase
   endfunction

   function automatic void push_item(op_kind_type kind, logic [PIX_W-1:0] pix);
      blur_req_t item;
      item.kind  = kind;
      item.pixel = pix;
      pixel_stream.push_back(item);
      items_queued++;
   endfunction

   // wait until every transaction is taken and every result is back
   task automatic drain_stream();
      while (items_taken != items_queued || expected_blur.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write, then read back; a write also restarts the frame
   task automatic csr_write(input reg_idx_type idx, input logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] stored;
      stored = (idx == REG_FRAME_WIDTH) ? (value & 32'h7FF) : (value & 32'hFFFF);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(4 * idx);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_FRAME_WIDTH) width_reg = FW_W'(stored);
      else height_reg = FH_W'(stored);
      col_pos   = 0;
      row_pos   = 0;
      flush_pos = 0;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== stored) begin
         $error("register %0d: expected %0d, actual %0d", idx, stored, csr_prdata);
         fail_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // one frame in raster order with stray transactions mixed in, cut short at cut
   task automatic queue_frame(input int unsigned w, input int unsigned h,
                              input int unsigned cut, output int unsigned n);
      int unsigned total;
      total = w * h + w;
      n = 0;
      for (int unsigned i = 0; i < total && i < cut; i++) begin
         if ($urandom_range(19) == 0) push_item((i < w * h) ? OP_FLUSH : OP_PIXEL, rand_pixel());
         push_item((i < w * h) ? OP_PIXEL : OP_FLUSH, rand_pixel());
         n++;
      end
   endtask

   initial begin
      int unsigned random_items;
      int unsigned phase;
      int unsigned frames;
      int unsigned total;
      int unsigned cut;
      int unsigned n;
      logic [CSR_DW-1:0] wr_w, wr_h;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // small frame with checkerboard extremes and stray transactions
      csr_write(REG_FRAME_WIDTH, 4);
      csr_write(REG_FRAME_HEIGHT, 3);
      push_item(OP_FLUSH, 8'h00);
      for (int i = 0; i < 12; i++) push_item(OP_PIXEL, ((i / 4 + i) % 2) ? 8'h00 : 8'hFF);
      push_item(OP_PIXEL, 8'hFF);
      for (int i = 0; i < 4; i++) push_item(OP_FLUSH, 8'hFF);
      drain_stream();

      // width zero behaves as one column
      csr_write(REG_FRAME_WIDTH, 0);
      csr_write(REG_FRAME_HEIGHT, 3);
      push_item(OP_PIXEL, 8'hFF);
      push_item(OP_PIXEL, 8'h00);
      push_item(OP_PIXEL, 8'hFF);
      push_item(OP_FLUSH, 8'h00);
      drain_stream();

      // tallest frame, abandoned partway by the next register write
      csr_write(REG_FRAME_WIDTH, 2);
      csr_write(REG_FRAME_HEIGHT, 65535);
      push_item(OP_PIXEL, 8'h00);
      push_item(OP_PIXEL, 8'hFF);
      push_item(OP_PIXEL, 8'hFF);
      push_item(OP_PIXEL, 8'h00);
      push_item(OP_PIXEL, 8'h80);
      push_item(OP_FLUSH, 8'h00);
      drain_stream();

      // widest row at full rate (over-range width clamps), height zero as
      // one row, then the first flushes of the bottom row
      send_idle_pct = 0;
      recv_idle_pct = 0;
      csr_write(REG_FRAME_WIDTH, 2047);
      csr_write(REG_FRAME_HEIGHT, 0);
      for (int i = 0; i < MAX_WIDTH; i++) push_item(OP_PIXEL, rand_pixel());
      for (int i = 0; i < WIDE_FLUSHES; i++) push_item(OP_FLUSH, rand_pixel());
      // long receiver hold-off just before the flush results start
      while (items_taken + WIDE_FLUSHES + 4 < items_queued) @(posedge clock);
      holdoff_asked++;
      drain_stream();
      send_idle_pct = 34;
      recv_idle_pct = 34;

      csr_write(REG_FRAME_WIDTH, 1024);
      csr_write(REG_FRAME_HEIGHT, 1);
      for (int i = 0; i < 8; i++) push_item(OP_PIXEL, rand_pixel());
      drain_stream();

      // random frames, mostly small, some cut short and restarted
      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(9))
            0:       wr_w = 0;
            1:       wr_w = 1;
            2:       wr_w = $urandom_range(24, 9);
            default: wr_w = $urandom_range(8, 2);
         endcase
         case ($urandom_range(9))
            0:       wr_h = 0;
            1:       wr_h = 1;
            2:       wr_h = 2;
            default: wr_h = $urandom_range(4, 3);
         endcase
         drain_stream();
         if ($urandom_range(1)) begin
            csr_write(REG_FRAME_WIDTH, wr_w);
            csr_write(REG_FRAME_HEIGHT, wr_h);
         end else begin
            csr_write(REG_FRAME_HEIGHT, wr_h);
            csr_write(REG_FRAME_WIDTH, wr_w);
         end
         // a stretch at full rate on both sides
         if (phase <= 1) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = 34;
            recv_idle_pct = 34;
         end
         frames = $urandom_range(2, 1);
         for (int f = 0; f < frames; f++) begin
            total = eff_cols() * eff_rows() + eff_cols();
            cut = ($urandom_range(9) == 0) ? $urandom_range(total - 1, 1) : total;
            queue_frame(eff_cols(), eff_rows(), cut, n);
            random_items += n;
            if (cut != total) break;
         end
         phase++;
      end

      drain_stream();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
